### rtl/wcrs_pkg.sv
// ----------------------------------------------------------------------------
// wcrs_pkg
// Shared types, constants and the cosine table builder for the warmup /
// cosine learning-rate schedule core.
// ----------------------------------------------------------------------------
package wcrs_pkg;

  // Default parameter values
  localparam int DefStepBits     = 32;
  localparam int DefCosTableDepth = 256;

  // Fixed-point constants
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
  localparam logic [16:0] OneQ16    = 17'd65536;

  // Register indexes on the configuration port
  localparam logic [1:0] RegPeak   = 2'd0;
  localparam logic [1:0] RegRatio  = 2'd1;
  localparam logic [1:0] RegWarmup = 2'd2;
  localparam logic [1:0] RegTotal  = 2'd3;

  // Which branch of the schedule an item takes
  typedef enum logic [1:0] {
    CLS_ERR   = 2'd0,
    CLS_WARM  = 2'd1,
    CLS_LATE  = 2'd2,
    CLS_DECAY = 2'd3
  } cls_e;

  // Unsigned 64-bit quotient by shift and subtract (elaboration only)
  function automatic logic [63:0] udiv64(input logic [63:0] num,
                                         input logic [63:0] den);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Cosine of an angle x (Q2.30) as Q1.16, via a truncated Taylor series.
  // Only evaluated at elaboration to fill the quarter-wave table.
  function automatic logic [16:0] rom_entry(input logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] denom;
    logic [63:0] rnd;
    logic signed [63:0] sum;
    x2   = (x * x) >> 30;
    term = 64'd1 << 30;
    sum  = 64'sd1 << 30;
    for (int n = 1; n < 40; n++) begin
      if (term != 64'd0) begin
        denom = 64'((2 * n - 1) * (2 * n));
        term  = (term * x2) >> 30;
        term  = udiv64(term, denom);
        if ((n % 2) == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    rnd = ($unsigned(sum) + 64'd8192) >> 14;
    if (rnd > 64'd65536) begin
      rnd = 64'd65536;
    end
    return rnd[16:0];
  endfunction

endpackage

### rtl/wcrs_div.sv
// ----------------------------------------------------------------------------
// wcrs_div
// Pipelined restoring divider: one quotient bit per stage. The caller makes
// sure the quotient fits in QW bits (top DW bits of the numerator below den).
// ----------------------------------------------------------------------------
module wcrs_div #(
  parameter int DW     = 32,
  parameter int QW     = 32,
  parameter int SIDE_W = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [DW+QW-1:0]  num_i,
  input  logic [DW-1:0]     den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [QW-1:0]     quo_o,
  output logic [SIDE_W-1:0] side_o
);

  logic              valid_q [QW];
  logic [DW-1:0]     rem_q   [QW];
  logic [QW-1:0]     low_q   [QW];
  logic [QW-1:0]     quo_q   [QW];
  logic [DW-1:0]     den_q   [QW];
  logic [SIDE_W-1:0] side_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              v_in;
    logic [DW-1:0]     rem_in;
    logic [QW-1:0]     low_in;
    logic [QW-1:0]     quo_in;
    logic [DW-1:0]     den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DW:0]       trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = num_i[DW+QW-1:QW];
      assign low_in  = num_i[QW-1:0];
      assign quo_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = valid_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign low_in  = low_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    // Shift in the next numerator bit and try a subtract
    assign trial = {rem_in, low_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
        low_q[k]  <= {low_in[QW-2:0], 1'b0};
        quo_q[k]  <= {quo_in[QW-2:0], ge};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QW-1];
  assign quo_o   = quo_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

### rtl/warmup_cosine_rate_schedule_core.sv
// ----------------------------------------------------------------------------
// warmup_cosine_rate_schedule_core
// Learning-rate schedule: linear warmup, then cosine decay to a floor.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one step number per item;
//   output channel (out_valid_o / out_stall_i) returns the rate (UQ4.28) and
//   a config_error flag for each item, in order.
//   Registers sit on an APB-style port at byte addresses 0, 4, 8, 12:
//   peak rate, floor ratio, warmup length, total length. Write them only
//   while no item is in flight.
//   Throughput: one item per cycle while the output is not stalled. The pipe is
//   the 32-stage restoring divider (one quotient bit per stage) plus two stages
//   ahead of it and six after it for the cosine lookup, interpolation and scaling.
//   A stall on the output while a result is held freezes the whole pipeline;
//   in_stall_o rises in the same cycle, so nothing is lost or repeated.
//   Reset empties the pipeline and loads the register defaults (total 1, the
//   others 0). The cosine table is a constant built at elaboration.
// ----------------------------------------------------------------------------
module warmup_cosine_rate_schedule_core #(
  parameter int STEP_BITS       = wcrs_pkg::DefStepBits,
  parameter int COS_TABLE_DEPTH = wcrs_pkg::DefCosTableDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] step_number_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] rate_o,
  output logic        config_error_o
);

  localparam int SW = (STEP_BITS < 32) ? STEP_BITS : 32;
  localparam int D  = COS_TABLE_DEPTH;
  localparam int IW = $clog2(D + 1);
  localparam int PW = 17 + $clog2(D + 1);
  localparam int NW = SW + 32;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [31:0] peak_q;
  logic [16:0] ratio_q;
  logic [31:0] warm_q;
  logic [31:0] total_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q  <= '0;
      ratio_q <= '0;
      warm_q  <= '0;
      total_q <= 32'd1;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        wcrs_pkg::RegPeak:   peak_q  <= pwdata;
        wcrs_pkg::RegRatio:  ratio_q <= pwdata[16:0];
        wcrs_pkg::RegWarmup: warm_q  <= pwdata;
        wcrs_pkg::RegTotal:  total_q <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[3:2])
      wcrs_pkg::RegPeak:   prdata = peak_q;
      wcrs_pkg::RegRatio:  prdata = {15'd0, ratio_q};
      wcrs_pkg::RegWarmup: prdata = warm_q;
      wcrs_pkg::RegTotal:  prdata = total_q;
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Values derived from configuration (settle while the block is idle)
  // --------------------------------------------------------------------------
  logic [SW-1:0] w_m;
  logic [SW-1:0] t_m;
  logic [48:0]   floor_prod;
  logic [31:0]   floor_q;
  logic [31:0]   span_q;
  logic          cerr_q;

  assign w_m        = warm_q[SW-1:0];
  assign t_m        = total_q[SW-1:0];
  assign floor_prod = 49'(peak_q) * 49'(ratio_q);

  always_ff @(posedge clk_i) begin
    floor_q <= floor_prod[47:16];
    span_q  <= peak_q - floor_q;
    cerr_q  <= (t_m == '0) || (w_m > t_m) || (ratio_q > wcrs_pkg::OneQ16);
  end

  // --------------------------------------------------------------------------
  // Pipeline control: the whole pipe advances unless a result is held
  // --------------------------------------------------------------------------
  logic en;
  logic out_valid_q;

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // --------------------------------------------------------------------------
  // Stage 1: capture step
  // --------------------------------------------------------------------------
  logic          v1_q;
  logic [SW-1:0] s1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= step_number_i[SW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: classify, build dividend and divisor
  // --------------------------------------------------------------------------
  logic          v2_q;
  logic [NW-1:0] num2_q;
  logic [SW-1:0] den2_q;
  wcrs_pkg::cls_e cls2_q;
  wcrs_pkg::cls_e cls_d;
  logic [SW:0]   s_inc;
  logic [SW+32:0] warm_prod;
  logic [SW-1:0] s_off;

  assign s_inc     = {1'b0, s1_q} + (SW+1)'(1);
  assign warm_prod = (SW+33)'(peak_q) * (SW+33)'(s_inc);
  assign s_off     = s1_q - w_m;

  always_comb begin
    priority if (cerr_q) begin
      cls_d = wcrs_pkg::CLS_ERR;
    end else if (s1_q < w_m) begin
      cls_d = wcrs_pkg::CLS_WARM;
    end else if (s1_q >= t_m) begin
      cls_d = wcrs_pkg::CLS_LATE;
    end else begin
      cls_d = wcrs_pkg::CLS_DECAY;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cls2_q <= cls_d;
      if (cls_d == wcrs_pkg::CLS_WARM) begin
        num2_q <= warm_prod[NW-1:0];
        den2_q <= w_m;
      end else begin
        num2_q <= NW'({s_off, 16'd0});
        den2_q <= t_m - w_m;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Divider: warmup rate or decay progress
  // --------------------------------------------------------------------------
  logic        vd;
  logic [31:0] qd;
  logic [1:0]  sided;

  wcrs_div #(
    .DW     (SW),
    .QW     (32),
    .SIDE_W (2)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v2_q),
    .num_i   (num2_q),
    .den_i   (den2_q),
    .side_i  (cls2_q),
    .valid_o (vd),
    .quo_o   (qd),
    .side_o  (sided)
  );

  // --------------------------------------------------------------------------
  // Post 1: fold progress onto the quarter wave, find table position
  // --------------------------------------------------------------------------
  logic [15:0]   prog;
  logic [16:0]   mirror;
  logic [16:0]   u;
  logic [PW-1:0] pos;
  logic [PW-17:0] idx_raw;
  logic [PW-16:0] idx_inc;
  logic [IW-1:0] i_d;
  logic [IW-1:0] j_d;

  assign prog    = (qd[31:16] != 16'd0) ? 16'hFFFF : qd[15:0];
  assign mirror  = wcrs_pkg::OneQ16 - {1'b0, prog};
  assign u       = prog[15] ? {mirror[15:0], 1'b0} : {prog, 1'b0};
  assign pos     = PW'(u) * PW'(D);
  assign idx_raw = pos[PW-1:16];
  assign idx_inc = {1'b0, idx_raw} + (PW-15)'(1);
  assign i_d     = (idx_raw > (PW-16)'(D)) ? IW'(D) : IW'(idx_raw);
  assign j_d     = (idx_inc > (PW-15)'(D)) ? IW'(D) : IW'(idx_inc);

  logic           v3_q;
  logic [IW-1:0]  i3_q;
  logic [IW-1:0]  j3_q;
  logic [15:0]    f3_q;
  logic           neg3_q;
  logic [31:0]    q3_q;
  wcrs_pkg::cls_e cls3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      i3_q   <= i_d;
      j3_q   <= j_d;
      f3_q   <= pos[15:0];
      neg3_q <= prog[15];
      q3_q   <= qd;
      cls3_q <= wcrs_pkg::cls_e'(sided);
    end
  end

  // --------------------------------------------------------------------------
  // Quarter-wave cosine table, built at elaboration
  // --------------------------------------------------------------------------
  logic [16:0] cos_tab [D+1];

  for (genvar k = 0; k <= D; k++) begin : g_tab
    localparam logic [63:0] Angle = (wcrs_pkg::HalfPiQ30 * 64'(k)) / 64'(D);
    localparam logic [16:0] Entry = wcrs_pkg::rom_entry(Angle);
    assign cos_tab[k] = Entry;
  end

  // --------------------------------------------------------------------------
  // Post 2: read both neighbors
  // --------------------------------------------------------------------------
  logic           v4_q;
  logic [16:0]    t0_4_q;
  logic [16:0]    t1_4_q;
  logic [15:0]    f4_q;
  logic           neg4_q;
  logic [31:0]    q4_q;
  wcrs_pkg::cls_e cls4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_4_q <= cos_tab[i3_q];
      t1_4_q <= cos_tab[j3_q];
      f4_q   <= f3_q;
      neg4_q <= neg3_q;
      q4_q   <= q3_q;
      cls4_q <= cls3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Post 3: interpolation product
  // --------------------------------------------------------------------------
  logic [16:0] tdiff;
  logic [32:0] iprod;

  assign tdiff = (t0_4_q > t1_4_q) ? (t0_4_q - t1_4_q) : 17'd0;
  assign iprod = 33'(tdiff) * 33'(f4_q);

  logic           v5_q;
  logic [16:0]    t0_5_q;
  logic [16:0]    corr5_q;
  logic           neg5_q;
  logic [31:0]    q5_q;
  wcrs_pkg::cls_e cls5_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_5_q  <= t0_4_q;
      corr5_q <= iprod[32:16];
      neg5_q  <= neg4_q;
      q5_q    <= q4_q;
      cls5_q  <= cls4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Post 4: cosine value and 1 + cos
  // --------------------------------------------------------------------------
  logic [16:0] qcos;
  logic [17:0] h2_d;

  assign qcos = t0_5_q - corr5_q;
  assign h2_d = neg5_q ? (18'(wcrs_pkg::OneQ16) - 18'(qcos))
                       : (18'(wcrs_pkg::OneQ16) + 18'(qcos));

  logic           v6_q;
  logic [17:0]    h2_6_q;
  logic [31:0]    q6_q;
  wcrs_pkg::cls_e cls6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (en) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h2_6_q <= h2_d;
      q6_q   <= q5_q;
      cls6_q <= cls5_q;
    end
  end

  // --------------------------------------------------------------------------
  // Post 5: scale the peak-to-floor span
  // --------------------------------------------------------------------------
  logic [49:0] sprod;

  assign sprod = 50'(span_q) * 50'(h2_6_q);

  logic           v7_q;
  logic [31:0]    dec7_q;
  logic [31:0]    q7_q;
  wcrs_pkg::cls_e cls7_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dec7_q <= sprod[48:17];
      q7_q   <= q6_q;
      cls7_q <= cls6_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: pick the branch result
  // --------------------------------------------------------------------------
  logic [31:0] rate_d;
  logic [31:0] rate_q;
  logic        err_q;

  always_comb begin
    unique case (cls7_q)
      wcrs_pkg::CLS_ERR:   rate_d = '0;
      wcrs_pkg::CLS_WARM:  rate_d = q7_q;
      wcrs_pkg::CLS_LATE:  rate_d = floor_q;
      wcrs_pkg::CLS_DECAY: rate_d = floor_q + dec7_q;
      default:             rate_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rate_q <= rate_d;
      err_q  <= (cls7_q == wcrs_pkg::CLS_ERR);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign rate_o         = rate_q;
  assign config_error_o = err_q;

endmodule
